// ===== hw/rtl/tdv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdv_pkg
// Widths, codes, stage payload types and helper functions shared by the
// three-source depth vote pipeline.
// ----------------------------------------------------------------------------
package tdv_pkg;

   // field widths
   localparam int DEPTH_W    = 16;
   localparam int WEIGHT_W   = 7;
   localparam int MARGIN_W   = 11;
   localparam int SHARE_W    = 9;
   localparam int NSRC       = 3;

   // derived arithmetic widths
   localparam int CNT_W      = $clog2(NSRC + 1);
   localparam int DEN_W      = WEIGHT_W + CNT_W;          // sum of up to three weights
   localparam int PROD_W     = DEPTH_W + WEIGHT_W;
   localparam int NUM_W      = PROD_W + CNT_W;            // sum of three products
   localparam int MSUM_W     = DEPTH_W + 1;               // stereo depth plus margin
   localparam int TRUST_W    = MSUM_W + DEN_W;
   localparam int QUO_W      = NUM_W - DEN_W;             // quotient width of every lane
   localparam int SHARE_FRAC = 8;                         // shares scaled by 256

   // divider organization
   localparam int DIV_STEPS  = 2;                         // quotient bits per stage
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;
   localparam int DIV_LANES  = NSRC + 1;
   localparam int LANE_DEPTH = NSRC;                      // lanes 0..NSRC-1 are shares

   // source slots
   localparam int SRC_STEREO = 0;
   localparam int SRC_UPPER  = 1;
   localparam int SRC_LOWER  = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = MARGIN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_UPPER  = 2'd0,
      CSR_WEIGHT_LOWER  = 2'd1,
      CSR_WEIGHT_STEREO = 2'd2,
      CSR_TRUST_MARGIN  = 2'd3
   } csr_index_type;

   typedef logic [DEPTH_W-1:0]  depth_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [MARGIN_W-1:0] margin_type;
   typedef logic [DEN_W-1:0]    den_type;
   typedef logic [NSRC-1:0]     mask_type;
   typedef logic [NSRC-1:0][WEIGHT_W-1:0] weight_vec_type;

   localparam logic [DEPTH_W-1:0] INLIER_RANGE = 16'd300;
   localparam logic [CNT_W-1:0]   MIN_AGREE    = 2'd2;
   localparam logic [SHARE_W-1:0] SHARE_ONE    = 9'd256;

   typedef struct packed {
      weight_type w_upper;
      weight_type w_lower;
      weight_type w_stereo;
      margin_type margin;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      w_upper:  7'd100,
      w_lower:  7'd40,
      w_stereo: 7'd5,
      margin:   11'd600
   };

   // one pixel as it enters
   typedef struct packed {
      depth_type [NSRC-1:0] dep;
      logic [NSRC-1:0]      ok;
   } sample_type;

   // after the vote
   typedef struct packed {
      depth_type [NSRC-1:0] dep;
      logic                 stereo_ok;
      mask_type             mask;
      logic                 fuse_pre;
   } pick_type;

   // after the weighting multipliers
   typedef struct packed {
      logic [NSRC-1:0][PROD_W-1:0] prod;
      den_type                     den;
      depth_type                   stereo_dep;
      logic                        stereo_ok;
      mask_type                    mask;
      logic                        fuse_pre;
   } wsum_type;

   // after summing and the trust product
   typedef struct packed {
      logic [NUM_W-1:0]                num;
      logic [TRUST_W-1:0]              trust;
      logic [DIV_LANES-1:0][NUM_W-1:0] divd;
      den_type                         den;
      depth_type                       stereo_dep;
      logic                            stereo_ok;
      mask_type                        mask;
      logic                            fuse_pre;
   } accum_type;

   // status that rides along with the divider
   typedef struct packed {
      depth_type stereo_dep;
      mask_type  mask;
      logic      den_nz;
      logic      fuse_ok;
      logic      override;
   } side_type;

   typedef struct packed {
      logic [DIV_LANES-1:0][NUM_W-1:0] divd;
      den_type                         den;
      side_type                        side;
   } div_in_type;

   typedef struct packed {
      logic [DIV_LANES-1:0][QUO_W-1:0] quo;
      side_type                        side;
   } div_out_type;

   typedef struct packed {
      den_type          rem;
      logic [QUO_W-1:0] word;   // dividend bits shift out, quotient bits shift in
   } div_lane_type;

   typedef struct packed {
      depth_type                     fused_depth;
      logic                          fused_ok;
      logic [NSRC-1:0][SHARE_W-1:0]  share;
   } result_type;

   // weights in source-slot order
   function automatic weight_vec_type weights_of(cfg_type cfg);
      weight_vec_type w;
      w[SRC_STEREO] = cfg.w_stereo;
      w[SRC_UPPER]  = cfg.w_upper;
      w[SRC_LOWER]  = cfg.w_lower;
      return w;
   endfunction

   // two readings agree when they are closer than the inlier range
   function automatic logic near_pair(depth_type a, depth_type b);
      depth_type diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff < INLIER_RANGE;
   endfunction

   // one restoring division step
   function automatic div_lane_type div_step(div_lane_type s, den_type den);
      logic [DEN_W:0] trial;
      div_lane_type   r;
      trial  = {s.rem, s.word[QUO_W-1]};
      r.word = {s.word[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         trial     = trial - {1'b0, den};
         r.word[0] = 1'b1;
      end
      r.rem = trial[DEN_W-1:0];
      return r;
   endfunction

endpackage

// ===== hw/rtl/tdv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdv_req_if / tdv_rsp_if
// Valid/ready channels for pixel readings in and fused results out.
// ----------------------------------------------------------------------------
interface tdv_req_if;
   import tdv_pkg::*;

   logic      valid;
   logic      ready;
   depth_type stereo_depth;
   logic      stereo_ok;
   depth_type upper_depth;
   logic      upper_ok;
   depth_type lower_depth;
   logic      lower_ok;

   modport source (
      output valid, stereo_depth, stereo_ok, upper_depth, upper_ok, lower_depth, lower_ok,
      input  ready
   );
   modport sink (
      input  valid, stereo_depth, stereo_ok, upper_depth, upper_ok, lower_depth, lower_ok,
      output ready
   );
endinterface

interface tdv_rsp_if;
   import tdv_pkg::*;

   logic                valid;
   logic                ready;
   depth_type           fused_depth;
   logic                fused_ok;
   logic [SHARE_W-1:0]  share_stereo;
   logic [SHARE_W-1:0]  share_upper;
   logic [SHARE_W-1:0]  share_lower;

   modport source (
      output valid, fused_depth, fused_ok, share_stereo, share_upper, share_lower,
      input  ready
   );
   modport sink (
      input  valid, fused_depth, fused_ok, share_stereo, share_upper, share_lower,
      output ready
   );
endinterface

// ===== hw/rtl/tdv_vote.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdv_vote
// Stage 1 picks the winning candidate and its inlier set; stage 2 forms the
// weighted products and the weight sum of that set.
// ----------------------------------------------------------------------------
module tdv_vote (
   input  logic                clock,
   input  logic                reset,
   input  tdv_pkg::cfg_type    cfg,
   input  logic                up_valid,
   output logic                up_ready,
   input  tdv_pkg::sample_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output tdv_pkg::wsum_type   dn_data
);
   import tdv_pkg::*;

   logic           s1_valid_ff, s2_valid_ff;
   logic           s1_ready, s2_ready;
   pick_type       s1_in, s1_ff;
   wsum_type       s2_in, s2_ff;

   logic [NSRC-1:0]  near_m [NSRC];
   logic [NSRC-1:0]  mask_m [NSRC];
   logic [CNT_W-1:0] cnt    [NSRC];
   logic [CNT_W-1:0] best_cnt;
   mask_type         best_mask;
   logic             best_stereo;
   logic             found;
   weight_vec_type   wv;

   // stage advance: a stage loads when empty or when its contents move on
   assign s2_ready = !s2_valid_ff || dn_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up_ready = s1_ready;

   // vote: inlier sets per candidate, later candidates win ties unless stereo
   always_comb begin
      for (int i = 0; i < NSRC; i++) begin
         cnt[i] = '0;
         for (int j = 0; j < NSRC; j++) begin
            near_m[i][j] = near_pair(up_data.dep[i], up_data.dep[j]);
            mask_m[i][j] = up_data.ok[i] & up_data.ok[j] & near_m[i][j];
            cnt[i]       = cnt[i] + CNT_W'(mask_m[i][j]);
         end
      end
      best_cnt    = '0;
      best_mask   = '0;
      best_stereo = 1'b0;
      found       = 1'b0;
      for (int i = 0; i < NSRC; i++) begin
         if (up_data.ok[i] &&
             ((cnt[i] > best_cnt) || ((i != SRC_STEREO) && (cnt[i] >= best_cnt)))) begin
            best_cnt    = cnt[i];
            best_mask   = mask_m[i];
            best_stereo = (i == SRC_STEREO);
            found       = 1'b1;
         end
      end
      s1_in.dep       = up_data.dep;
      s1_in.stereo_ok = up_data.ok[SRC_STEREO];
      s1_in.mask      = best_mask;
      // a lone camera reading gives no depth
      s1_in.fuse_pre  = found && (best_stereo || (best_cnt >= MIN_AGREE));
   end

   // weighting: masked products and weight sum
   always_comb begin
      wv               = weights_of(cfg);
      s2_in.den        = '0;
      for (int j = 0; j < NSRC; j++) begin
         s2_in.prod[j] = s1_ff.mask[j] ? (PROD_W'(wv[j]) * PROD_W'(s1_ff.dep[j])) : '0;
         s2_in.den     = s2_in.den + (s1_ff.mask[j] ? DEN_W'(wv[j]) : '0);
      end
      s2_in.stereo_dep = s1_ff.dep[SRC_STEREO];
      s2_in.stereo_ok  = s1_ff.stereo_ok;
      s2_in.mask       = s1_ff.mask;
      s2_in.fuse_pre   = s1_ff.fuse_pre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= up_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) s1_ff <= s1_in;
      if (s2_ready) s2_ff <= s2_in;
   end

   assign dn_valid = s2_valid_ff;
   assign dn_data  = s2_ff;

   // a usable winner always counts itself among its inliers
   a_win_has_inlier: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.fuse_pre |-> s1_ff.mask != '0)
      else $error("vote: usable winner with empty inlier set");

endmodule

// ===== hw/rtl/tdv_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdv_accum
// Stage 3 sums the products, forms the rounded dividends and the trust
// product; stage 4 makes the trust compare and the validity flags.
// ----------------------------------------------------------------------------
module tdv_accum (
   input  logic                clock,
   input  logic                reset,
   input  tdv_pkg::cfg_type    cfg,
   input  logic                up_valid,
   output logic                up_ready,
   input  tdv_pkg::wsum_type   up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output tdv_pkg::div_in_type dn_data
);
   import tdv_pkg::*;

   logic             a3_valid_ff, a4_valid_ff;
   logic             a3_ready, a4_ready;
   accum_type        a3_in, a3_ff;
   div_in_type       a4_in, a4_ff;

   logic [NUM_W-1:0]  num;
   logic [NUM_W-1:0]  half;
   logic [MSUM_W-1:0] msum;
   weight_vec_type    wv;

   assign a4_ready = !a4_valid_ff || dn_ready;
   assign a3_ready = !a3_valid_ff || a4_ready;
   assign up_ready = a3_ready;

   // sums, round-to-nearest dividends, trust product
   always_comb begin
      wv   = weights_of(cfg);
      num  = '0;
      for (int j = 0; j < NSRC; j++) begin
         num = num + NUM_W'(up_data.prod[j]);
      end
      half = NUM_W'(up_data.den >> 1);
      a3_in.num              = num;
      a3_in.divd[LANE_DEPTH] = num + half;
      for (int j = 0; j < NSRC; j++) begin
         a3_in.divd[j] = (NUM_W'(wv[j]) << SHARE_FRAC) + half;
      end
      msum               = MSUM_W'(up_data.stereo_dep) + MSUM_W'(cfg.margin);
      a3_in.trust        = TRUST_W'(msum) * TRUST_W'(up_data.den);
      a3_in.den          = up_data.den;
      a3_in.stereo_dep   = up_data.stereo_dep;
      a3_in.stereo_ok    = up_data.stereo_ok;
      a3_in.mask         = up_data.mask;
      a3_in.fuse_pre     = up_data.fuse_pre;
   end

   // stereo takes over when the fused mean lies beyond it by the margin
   always_comb begin
      a4_in.divd            = a3_ff.divd;
      a4_in.den             = a3_ff.den;
      a4_in.side.stereo_dep = a3_ff.stereo_dep;
      a4_in.side.mask       = a3_ff.mask;
      a4_in.side.den_nz     = (a3_ff.den != '0);
      a4_in.side.fuse_ok    = a3_ff.fuse_pre && (a3_ff.den != '0);
      a4_in.side.override   = a3_ff.stereo_ok && (TRUST_W'(a3_ff.num) > a3_ff.trust);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a3_valid_ff <= 1'b0;
         a4_valid_ff <= 1'b0;
      end else begin
         if (a3_ready) a3_valid_ff <= up_valid;
         if (a4_ready) a4_valid_ff <= a3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a3_ready) a3_ff <= a3_in;
      if (a4_ready) a4_ff <= a4_in;
   end

   assign dn_valid = a4_valid_ff;
   assign dn_data  = a4_ff;

endmodule

// ===== hw/rtl/tdv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdv_div
// Pipelined restoring divider: four lanes share one divisor (the weight sum),
// DIV_STEPS quotient bits per stage. Status travels alongside.
// ----------------------------------------------------------------------------
module tdv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  tdv_pkg::div_in_type  up_data,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output tdv_pkg::div_out_type dn_data
);
   import tdv_pkg::*;

   logic [DIV_STAGES-1:0]          valid_ff;
   logic [DIV_STAGES-1:0]          valid_in;
   logic [DIV_STAGES:0]            rdy;
   div_lane_type [DIV_LANES-1:0]   lane_ff  [DIV_STAGES];
   div_lane_type [DIV_LANES-1:0]   lane_src [DIV_STAGES];
   div_lane_type [DIV_LANES-1:0]   lane_in  [DIV_STAGES];
   den_type                        den_ff   [DIV_STAGES];
   den_type                        den_src  [DIV_STAGES];
   side_type                       side_ff  [DIV_STAGES];
   side_type                       side_src [DIV_STAGES];
   div_lane_type                   cur;

   // backpressure chain, last stage first
   always_comb begin
      rdy[DIV_STAGES] = dn_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end
   assign up_ready = rdy[0];

   // stage inputs: first stage splits the dividend, later stages take the previous
   always_comb begin
      valid_in[0] = up_valid;
      den_src[0]  = up_data.den;
      side_src[0] = up_data.side;
      for (int l = 0; l < DIV_LANES; l++) begin
         lane_src[0][l].rem  = up_data.divd[l][NUM_W-1:QUO_W];
         lane_src[0][l].word = up_data.divd[l][QUO_W-1:0];
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
         den_src[k]  = den_ff[k-1];
         side_src[k] = side_ff[k-1];
         lane_src[k] = lane_ff[k-1];
      end
   end

   // division steps of each stage
   always_comb begin
      cur = '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            cur = lane_src[k][l];
            for (int s = 0; s < DIV_STEPS; s++) begin
               cur = div_step(cur, den_src[k]);
            end
            lane_in[k][l] = cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (rdy[k]) begin
            lane_ff[k] <= lane_in[k];
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   // last stage: quotients and status out
   assign dn_valid = valid_ff[DIV_STAGES-1];
   always_comb begin
      dn_data.side = side_ff[DIV_STAGES-1];
      for (int l = 0; l < DIV_LANES; l++) begin
         dn_data.quo[l] = lane_ff[DIV_STAGES-1][l].word;
      end
   end

   // partial remainder stays below a nonzero divisor in every lane
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rem_chk
      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
         a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
            valid_ff[k] && (den_ff[k] != '0) |-> lane_ff[k][l].rem < den_ff[k])
            else $error("div: partial remainder not below divisor");
      end
   end

endmodule

// ===== hw/rtl/three_source_depth_vote.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_source_depth_vote
// Per-pixel vote between stereo, upper and lower depth readings, with
// weighted fusion, stereo trust override and normalized source shares.
// ----------------------------------------------------------------------------
// Pipeline: 13 register stages (vote 2, accumulate 2, divider 8, output 1).
// Throughput: one pixel per clock; every stage holds under backpressure and
//    bubbles close up, so requests are taken while a result waits.
// The divider (2 quotient bits per stage over 16 bits) sets the depth.
// Reset: clears all valid bits and loads the default weights and margin.
// ----------------------------------------------------------------------------
module three_source_depth_vote (
   input  logic                          clock,
   input  logic                          reset,
   tdv_req_if.sink                       req_ch,
   tdv_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [tdv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tdv_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tdv_pkg::*;

   cfg_type     cfg_ff;
   sample_type  sample;

   logic        vote_valid, vote_ready;
   wsum_type    vote_data;
   logic        acc_valid, acc_ready;
   div_in_type  acc_data;
   logic        div_valid, div_ready;
   div_out_type div_data;

   logic        rsp_valid_ff;
   result_type  out_in, out_ff;
   depth_type   pick_depth;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WEIGHT_UPPER:  cfg_ff.w_upper  <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_LOWER:  cfg_ff.w_lower  <= csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_STEREO: cfg_ff.w_stereo <= csr_wdata[WEIGHT_W-1:0];
            CSR_TRUST_MARGIN:  cfg_ff.margin   <= csr_wdata[MARGIN_W-1:0];
         endcase
      end
   end

   // request payload in source-slot order
   always_comb begin
      sample.dep[SRC_STEREO] = req_ch.stereo_depth;
      sample.dep[SRC_UPPER]  = req_ch.upper_depth;
      sample.dep[SRC_LOWER]  = req_ch.lower_depth;
      sample.ok[SRC_STEREO]  = req_ch.stereo_ok;
      sample.ok[SRC_UPPER]   = req_ch.upper_ok;
      sample.ok[SRC_LOWER]   = req_ch.lower_ok;
   end

   tdv_vote u_vote (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (req_ch.valid),
      .up_ready (req_ch.ready),
      .up_data  (sample),
      .dn_valid (vote_valid),
      .dn_ready (vote_ready),
      .dn_data  (vote_data)
   );

   tdv_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (vote_valid),
      .up_ready (vote_ready),
      .up_data  (vote_data),
      .dn_valid (acc_valid),
      .dn_ready (acc_ready),
      .dn_data  (acc_data)
   );

   tdv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (acc_valid),
      .up_ready (acc_ready),
      .up_data  (acc_data),
      .dn_valid (div_valid),
      .dn_ready (div_ready),
      .dn_data  (div_data)
   );

   // result assembly; invalid results carry zero depth
   always_comb begin
      pick_depth = div_data.side.override ? div_data.side.stereo_dep
                                          : div_data.quo[LANE_DEPTH];
      out_in.fused_ok    = div_data.side.fuse_ok;
      out_in.fused_depth = div_data.side.fuse_ok ? pick_depth : '0;
      for (int j = 0; j < NSRC; j++) begin
         out_in.share[j] = (div_data.side.den_nz && div_data.side.mask[j])
                           ? div_data.quo[j][SHARE_W-1:0] : '0;
      end
   end

   // output register
   assign div_ready = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) out_ff <= out_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.fused_depth  = out_ff.fused_depth;
   assign rsp_ch.fused_ok     = out_ff.fused_ok;
   assign rsp_ch.share_stereo = out_ff.share[SRC_STEREO];
   assign rsp_ch.share_upper  = out_ff.share[SRC_UPPER];
   assign rsp_ch.share_lower  = out_ff.share[SRC_LOWER];

   a_invalid_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_ff.fused_ok |-> out_ff.fused_depth == '0)
      else $error("top: invalid result with nonzero depth");

   a_share_at_most_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_ff.share[SRC_STEREO] <= SHARE_ONE) &&
                       (out_ff.share[SRC_UPPER] <= SHARE_ONE) &&
                       (out_ff.share[SRC_LOWER] <= SHARE_ONE))
      else $error("top: source share above one");

endmodule
